/* src/mhgs_pkg.sv */
// Shared constants for the max hourglass sum block.
// Used by the top level and its port checker; depends on nothing.
package mhgs_pkg;

   // Width of the matrix side register and its value after reset.
   localparam int SIDE_W     = 7;
   localparam int RESET_SIDE = 3;

   // Result queue between the max stage and the output port.
   localparam int RSP_DEPTH  = 4;
   localparam int RSP_PTR_W  = 2;
   localparam int RSP_CNT_W  = 3;

   // Per-word control bits that travel down the pipeline.
   typedef struct packed {
      logic valid;
      logic sum_en;
      logic last;
   } stage_ctrl_type;

endpackage

/* src/mhgs_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// A read of the address written in the same cycle returns the old data.
// No dependencies.
module mhgs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/max_hourglass_sum_3x3.sv */
// Max 3x3 hourglass sum over a square matrix streamed in raster order.
// Throughput: one element per cycle; the line buffer RAM is read at accept and
// written back in the next cycle, so every element costs one read and one write.
// The result word passes the s1 and s2 registers, then the result queue.
// Input stalls only while 4 results are pending. Reset is synchronous; the
// line buffer RAM is not cleared, so no clearing pass follows reset.
module max_hourglass_sum_3x3 #(
   parameter int MAX_SIDE   = 64,
   parameter int DATA_WIDTH = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // config: matrix side
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [mhgs_pkg::SIDE_W-1:0]               csr_data,
   // request stream
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [((DATA_WIDTH+7)/8)*8-1:0]           req_tdata,  // element_value
   // response stream
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [((DATA_WIDTH+3+7)/8)*8-1:0]         rsp_tdata,  // max_sum
   output logic                                      rsp_tuser   // found
);

   localparam int CW     = $clog2(MAX_SIDE);
   localparam int CMPW   = ((CW > mhgs_pkg::SIDE_W) ? CW : mhgs_pkg::SIDE_W) + 1;
   localparam int SUM_W  = DATA_WIDTH + 3;
   localparam int OUT_TW = ((SUM_W + 7) / 8) * 8;
   localparam int RAM_W  = 2 * DATA_WIDTH;
   localparam logic signed [SUM_W-1:0] SUM_MOST_NEG = {1'b1, {(SUM_W-1){1'b0}}};

   // ---------------- config and position counters ----------------
   logic [mhgs_pkg::SIDE_W-1:0] side_ff;
   logic [CMPW-1:0]             side_eff;
   logic [CW-1:0]               col_ff, row_ff;
   logic                        csr_wr, accept;
   logic                        col_last, row_last;
   mhgs_pkg::stage_ctrl_type    ctrl0;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign accept    = req_tvalid && req_tready;

   always_comb begin
      side_eff = CMPW'(side_ff);
      if (side_ff == '0) begin
         side_eff = CMPW'(1);
      end else if (side_eff > CMPW'(MAX_SIDE)) begin
         side_eff = CMPW'(MAX_SIDE);
      end
   end

   assign col_last     = (CMPW'(col_ff) + CMPW'(1)) >= side_eff;
   assign row_last     = (CMPW'(row_ff) + CMPW'(1)) >= side_eff;
   assign ctrl0.valid  = accept;
   assign ctrl0.sum_en = (row_ff >= CW'(2)) && (col_ff >= CW'(2));
   assign ctrl0.last   = col_last && row_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= mhgs_pkg::SIDE_W'(mhgs_pkg::RESET_SIDE);
         col_ff  <= '0;
         row_ff  <= '0;
      end else if (csr_wr) begin
         side_ff <= csr_data;
         col_ff  <= '0;
         row_ff  <= '0;
      end else if (accept) begin
         if (col_last) begin
            col_ff <= '0;
            row_ff <= row_last ? '0 : row_ff + CW'(1);
         end else begin
            col_ff <= col_ff + CW'(1);
         end
      end
   end

   // ---------------- line buffer: {row above above, row above} per column ----
   mhgs_pkg::stage_ctrl_type s1_ctrl_ff;
   logic signed [DATA_WIDTH-1:0] s1_cur_ff;
   logic [CW-1:0]                s1_addr_ff;
   logic                         s1_fwd_ff;
   logic [RAM_W-1:0]             s1_fwd_data_ff;
   logic [RAM_W-1:0]             ram_rd_data, col_data;
   logic signed [DATA_WIDTH-1:0] top, mid;
   logic                         fwd_hit;

   mhgs_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_SIDE)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_ctrl_ff.valid),
      .wr_addr (s1_addr_ff),
      .wr_data ({mid, s1_cur_ff}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   // same column written by the word ahead this cycle: take its write data
   assign fwd_hit  = s1_ctrl_ff.valid && (s1_addr_ff == col_ff);
   assign col_data = s1_fwd_ff ? s1_fwd_data_ff : ram_rd_data;
   assign top      = col_data[RAM_W-1:DATA_WIDTH];
   assign mid      = col_data[DATA_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff <= '0;
      end else begin
         s1_ctrl_ff <= ctrl0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff      <= req_tdata[DATA_WIDTH-1:0];
         s1_addr_ff     <= col_ff;
         s1_fwd_ff      <= fwd_hit;
         s1_fwd_data_ff <= {mid, s1_cur_ff};
      end
   end

   // ---------------- window and hourglass sum ----------------
   logic signed [DATA_WIDTH-1:0] top_d1_ff, top_d2_ff, mid_d1_ff, cur_d1_ff, cur_d2_ff;
   logic signed [SUM_W-1:0]      sum;
   mhgs_pkg::stage_ctrl_type     s2_ctrl_ff;
   logic signed [SUM_W-1:0]      s2_sum_ff;

   assign sum = SUM_W'(top_d2_ff) + SUM_W'(top_d1_ff) + SUM_W'(top)
              + SUM_W'(mid_d1_ff)
              + SUM_W'(cur_d2_ff) + SUM_W'(cur_d1_ff) + SUM_W'(s1_cur_ff);

   always_ff @(posedge clock) begin
      if (reset || csr_wr) begin
         top_d1_ff <= '0;
         top_d2_ff <= '0;
         mid_d1_ff <= '0;
         cur_d1_ff <= '0;
         cur_d2_ff <= '0;
      end else if (s1_ctrl_ff.valid) begin
         top_d2_ff <= top_d1_ff;
         top_d1_ff <= top;
         mid_d1_ff <= mid;
         cur_d2_ff <= cur_d1_ff;
         cur_d1_ff <= s1_cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctrl_ff <= '0;
      end else begin
         s2_ctrl_ff <= s1_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ctrl_ff.valid) begin
         s2_sum_ff <= sum;
      end
   end

   // ---------------- running max ----------------
   logic signed [SUM_W-1:0] max_ff, max_in;
   logic                    found_ff, found_in;
   logic                    push;

   always_comb begin
      max_in   = max_ff;
      found_in = found_ff;
      if (s2_ctrl_ff.sum_en) begin
         if (!found_ff || (s2_sum_ff > max_ff)) begin
            max_in = s2_sum_ff;
         end
         found_in = 1'b1;
      end
   end

   assign push = s2_ctrl_ff.valid && s2_ctrl_ff.last;

   always_ff @(posedge clock) begin
      if (reset || csr_wr) begin
         max_ff   <= SUM_MOST_NEG;
         found_ff <= 1'b0;
      end else if (s2_ctrl_ff.valid) begin
         if (s2_ctrl_ff.last) begin
            max_ff   <= SUM_MOST_NEG;
            found_ff <= 1'b0;
         end else begin
            max_ff   <= max_in;
            found_ff <= found_in;
         end
      end
   end

   // ---------------- result queue ----------------
   logic [SUM_W-1:0]                 q_max_ff   [0:mhgs_pkg::RSP_DEPTH-1];
   logic                             q_found_ff [0:mhgs_pkg::RSP_DEPTH-1];
   logic [mhgs_pkg::RSP_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [mhgs_pkg::RSP_CNT_W-1:0]   q_count_ff;
   logic [mhgs_pkg::RSP_CNT_W-1:0]   pend_ff;  // results owed, from accept to delivery
   logic                             pop, owe;

   assign pop        = rsp_tvalid && rsp_tready;
   assign owe        = accept && ctrl0.last;
   assign rsp_tvalid = q_count_ff != '0;
   assign rsp_tdata  = OUT_TW'(q_max_ff[rd_ptr_ff]);
   assign rsp_tuser  = q_found_ff[rd_ptr_ff];
   assign req_tready = pend_ff < mhgs_pkg::RSP_CNT_W'(mhgs_pkg::RSP_DEPTH);

   always_ff @(posedge clock) begin
      if (push) begin
         q_max_ff[wr_ptr_ff]   <= max_in;
         q_found_ff[wr_ptr_ff] <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
         pend_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + mhgs_pkg::RSP_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + mhgs_pkg::RSP_PTR_W'(1);
         end
         if (push && !pop) begin
            q_count_ff <= q_count_ff + mhgs_pkg::RSP_CNT_W'(1);
         end else if (pop && !push) begin
            q_count_ff <= q_count_ff - mhgs_pkg::RSP_CNT_W'(1);
         end
         if (owe && !pop) begin
            pend_ff <= pend_ff + mhgs_pkg::RSP_CNT_W'(1);
         end else if (pop && !owe) begin
            pend_ff <= pend_ff - mhgs_pkg::RSP_CNT_W'(1);
         end
      end
   end

endmodule

/* src/mhgs_check.sv */
// Port-level checker for max_hourglass_sum_3x3, bound to the top level.
// Depends on mhgs_pkg for the config width.
module mhgs_check #(
   parameter int DATA_WIDTH = 16
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [mhgs_pkg::SIDE_W-1:0]         csr_data,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [((DATA_WIDTH+7)/8)*8-1:0]     req_tdata,   // element_value
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((DATA_WIDTH+3+7)/8)*8-1:0]   rsp_tdata,   // max_sum
   input logic                                rsp_tuser    // found
);

   localparam int SUM_W = DATA_WIDTH + 3;
   localparam logic signed [SUM_W-1:0] SUM_MOST_NEG = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] SUM_LOW  =
      SUM_W'(-7 * (longint'(1) << (DATA_WIDTH - 1)));
   localparam logic signed [SUM_W-1:0] SUM_HIGH =
      SUM_W'(7 * ((longint'(1) << (DATA_WIDTH - 1)) - 1));

   logic signed [SUM_W-1:0] max_sum;
   assign max_sum = rsp_tdata[SUM_W-1:0];

   // no result word during or right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // no hourglass: the sum reads as the most negative value
   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> max_sum == SUM_MOST_NEG)
      else $error("empty matrix with a sum");

   // a real hourglass sum is bounded by seven elements
   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (max_sum >= SUM_LOW) && (max_sum <= SUM_HIGH))
      else $error("hourglass sum out of range");

endmodule

bind max_hourglass_sum_3x3 mhgs_check #(.DATA_WIDTH(DATA_WIDTH)) u_mhgs_check (.*);
